/* hdl/lcba_pkg.sv */
// Shared widths, codes and defaults for the link-chain bandwidth admission block.
`default_nettype none

package lcba_pkg;

    // Defaults for the top-level parameters.
    localparam int LINKS_DEF    = 64;
    localparam int BW_WIDTH_DEF = 16;

    // Fixed field widths of the channels and the configuration port.
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int AMT_W  = 16;
    localparam int NODE_W = 7;
    localparam int STAT_W = 2;
    localparam int NECK_W = 16;

    // Link count after reset, before it is clamped to the store size.
    localparam int LINK_COUNT_RST = 64;

    // Operation codes of a request.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_XFER = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* hdl/lcba_cmd_if.sv */
// Request channel: valid/ready handshake with the load or transfer payload.
`default_nettype none

interface lcba_cmd_if import lcba_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  link_index;
    logic [AMT_W-1:0]  amount;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] last_node;

    modport source (
        output valid, op, link_index, amount, first_node, last_node,
        input  ready
    );

    modport sink (
        input  valid, op, link_index, amount, first_node, last_node,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/lcba_res_if.sv */
// Result channel: valid/ready handshake with status and bottleneck.
`default_nettype none

interface lcba_res_if import lcba_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [NECK_W-1:0] bottleneck;

    modport source (
        output valid, status, bottleneck,
        input  ready
    );

    modport sink (
        input  valid, status, bottleneck,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/lcba_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module lcba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/lcba_alu.sv */
// Shared subtractor: difference and borrow, used for compares and updates.
`default_nettype none

module lcba_alu #(
    parameter int WIDTH = 16
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    output logic      [WIDTH-1:0] diff,
    output logic                  borrow
);

    logic [WIDTH:0] full_diff;

    // One wide subtract; the borrow says a is below b.
    always_comb
    begin
        full_diff = {1'b0, a} - {1'b0, b};
        diff      = full_diff[WIDTH-1:0];
        borrow    = full_diff[WIDTH];
    end

endmodule

`default_nettype wire

/* hdl/link_chain_bandwidth_admission.sv */
// Top level: link bandwidth store, scan/update sequencer and result register.
//
//   Port       Dir   Kind        Content
//   cmd        in    valid/ready op, link_index, amount, first_node, last_node
//   res        out   valid/ready status, bottleneck
//   cfg_wr_*   in    write only  link_count (7 bits)
//
// A load, a request with a bad node and a request with equal nodes finish in
// the cycle they are taken. A request over L links is scanned for its minimum,
// decided on and, when granted, updated link by link; the single RAM read port
// and the shared subtractor make the scan and the update serial.
// Reset clears control state and sets link_count to min(64, LINKS); the link
// store is not cleared. A stalled result only blocks the next request.
`default_nettype none

module link_chain_bandwidth_admission import lcba_pkg::*; #(
    parameter int LINKS    = LINKS_DEF,
    parameter int BW_WIDTH = BW_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    lcba_cmd_if.sink              cmd,
    lcba_res_if.source            res,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data
);

    localparam int AW = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int OW = (BW_WIDTH > AMT_W) ? BW_WIDTH : AMT_W;
    localparam logic [CNT_W-1:0] COUNT_RST =
        CNT_W'((LINK_COUNT_RST > LINKS) ? LINKS : LINK_COUNT_RST);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SCAN_END = 6'b000100,
        S_DECIDE   = 6'b001000,
        S_UPD      = 6'b010000,
        S_UPD_END  = 6'b100000
    } state_t;

    state_t               state_reg,  state_next;
    logic [CNT_W-1:0]     link_count_reg;
    logic [AMT_W-1:0]     amount_reg, amount_next;
    logic [BW_WIDTH-1:0]  neck_reg,   neck_next;
    logic [AW-1:0]        ptr_reg,    ptr_next;
    logic [AW-1:0]        first_reg,  first_next;
    logic [AW-1:0]        last_reg,   last_next;
    logic [AW-1:0]        wptr_reg,   wptr_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 res_valid_reg, res_valid_next;
    status_t              res_status_reg, res_status_next;
    logic [NECK_W-1:0]    res_neck_reg,   res_neck_next;
    logic                 res_set;

    logic [CNT_W-1:0]     n_eff;
    logic [CNT_W:0]       n_plus1;
    logic                 accept;
    logic                 load_ok;
    logic                 node_bad;
    logic                 range_empty;
    logic [NODE_W-1:0]    lo_node, hi_node;
    logic [NODE_W-1:0]    first_link, last_link;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [BW_WIDTH-1:0]  ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [BW_WIDTH-1:0]  ram_rd_data;

    logic [OW-1:0]        alu_a, alu_b, alu_diff;
    logic                 alu_borrow;

    // Link bandwidth store.
    lcba_ram #(
        .WIDTH (BW_WIDTH),
        .DEPTH (LINKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared subtractor for minimum search, grant decision and update.
    lcba_alu #(
        .WIDTH (OW)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_count_reg <= COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            link_count_reg <= cfg_wr_data;
        end
    end

    // Decode of the incoming request against the effective link count.
    always_comb
    begin
        n_eff       = (32'(link_count_reg) > LINKS) ? CNT_W'(LINKS) : link_count_reg;
        n_plus1     = {1'b0, n_eff} + (CNT_W+1)'(1);
        load_ok     = {1'b0, cmd.link_index} < n_eff;
        node_bad    = (cmd.first_node == '0) || (cmd.last_node == '0) ||
                      ({1'b0, cmd.first_node} > n_plus1) ||
                      ({1'b0, cmd.last_node} > n_plus1);
        range_empty = (cmd.first_node == cmd.last_node);
        lo_node     = (cmd.first_node < cmd.last_node) ? cmd.first_node : cmd.last_node;
        hi_node     = (cmd.first_node < cmd.last_node) ? cmd.last_node : cmd.first_node;
        first_link  = lo_node - NODE_W'(1);
        last_link   = hi_node - NODE_W'(2);
    end

    assign cmd.ready = (state_reg == S_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;

    // Operand selection for the shared subtractor.
    always_comb
    begin
        case (state_reg)
            S_SCAN, S_SCAN_END:
            begin
                alu_a = OW'(ram_rd_data);
                alu_b = OW'(neck_reg);
            end
            S_DECIDE:
            begin
                alu_a = OW'(neck_reg);
                alu_b = OW'(amount_reg);
            end
            default:
            begin
                alu_a = OW'(ram_rd_data);
                alu_b = OW'(amount_reg);
            end
        endcase
    end

    // Sequencer: scan for the minimum, decide, then write back the reduced links.
    always_comb
    begin
        state_next      = state_reg;
        amount_next     = amount_reg;
        neck_next       = neck_reg;
        ptr_next        = ptr_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        wptr_next       = wptr_reg;
        rd_pend_next    = 1'b0;
        res_set         = 1'b0;
        res_status_next = res_status_reg;
        res_neck_next   = res_neck_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wptr_reg;
        ram_wr_data     = BW_WIDTH'(alu_diff);
        ram_rd_en       = 1'b0;
        ram_rd_addr     = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_LOAD)
                    begin
                        res_set         = 1'b1;
                        res_neck_next   = '0;
                        res_status_next = load_ok ? ST_OK : ST_BAD_INDEX;
                        ram_wr_en       = load_ok;
                        ram_wr_addr     = AW'(cmd.link_index);
                        ram_wr_data     = BW_WIDTH'(cmd.amount);
                    end
                    else if (node_bad)
                    begin
                        res_set         = 1'b1;
                        res_neck_next   = '0;
                        res_status_next = ST_BAD_INDEX;
                    end
                    else if (range_empty)
                    begin
                        res_set         = 1'b1;
                        res_neck_next   = NECK_W'({BW_WIDTH{1'b1}});
                        res_status_next = ST_OK;
                    end
                    else
                    begin
                        amount_next = cmd.amount;
                        neck_next   = '1;
                        ptr_next    = AW'(first_link);
                        first_next  = AW'(first_link);
                        last_next   = AW'(last_link);
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                ram_rd_en    = 1'b1;
                rd_pend_next = 1'b1;
                if (rd_pend_reg && alu_borrow)
                begin
                    neck_next = ram_rd_data;
                end
                if (ptr_reg == last_reg)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_SCAN_END:
            begin
                if (alu_borrow)
                begin
                    neck_next = ram_rd_data;
                end
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (alu_borrow)
                begin
                    res_set         = 1'b1;
                    res_status_next = ST_REFUSED;
                    res_neck_next   = NECK_W'(neck_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    ptr_next   = first_reg;
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                ram_rd_en    = 1'b1;
                rd_pend_next = 1'b1;
                wptr_next    = ptr_reg;
                ram_wr_en    = rd_pend_reg;
                if (ptr_reg == last_reg)
                begin
                    state_next = S_UPD_END;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_UPD_END:
            begin
                ram_wr_en       = 1'b1;
                res_set         = 1'b1;
                res_status_next = ST_OK;
                res_neck_next   = NECK_W'(neck_reg);
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: loaded on completion, cleared when taken.
    always_comb
    begin
        if (res_set)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        amount_reg     <= amount_next;
        neck_reg       <= neck_next;
        ptr_reg        <= ptr_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        wptr_reg       <= wptr_next;
        res_status_reg <= res_status_next;
        res_neck_reg   <= res_neck_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.status     = res_status_reg;
    assign res.bottleneck = res_neck_reg;

    // A store write outside the update states comes only from an accepted load.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && (state_reg == S_IDLE)) |-> (accept && (cmd.op == OP_LOAD)))
        else $error("link store written without a load or an update");

    // The update only runs when the bottleneck covers the workload.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPD) || (state_reg == S_UPD_END)) |->
        (32'(neck_reg) >= 32'(amount_reg)))
        else $error("update running on a refused request");

    // The scan pointer never passes the last link of the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) || (state_reg == S_UPD)) |-> (ptr_reg <= last_reg))
        else $error("scan pointer beyond the end of the range");

    // A finished request always leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPD_END) || (state_reg == S_DECIDE && alu_borrow)) |=>
        res_valid_reg)
        else $error("request finished without a result");

endmodule

`default_nettype wire

/* tb/link_chain_bandwidth_admission_test.sv */
// Self-checking testbench for the link-chain bandwidth admission block.
`default_nettype none

module link_chain_bandwidth_admission_test import lcba_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINKS          = LINKS_DEF;
    localparam int IDLE_MAX       = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 2 * LINKS + 16;

    // One result of the block: status and bottleneck.
    typedef struct packed {
        status_t           status;
        logic [NECK_W-1:0] neck;
    } verdict_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // A directed row; a config row carries its link count in amount.
    typedef struct packed {
        row_kind_t         kind;
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [AMT_W-1:0]  amount;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        bit                pinned;
        verdict_t          want;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    lcba_cmd_if cmd_ch ();
    lcba_res_if res_ch ();

    // Hand-written expectation travelling alongside the current request.
    bit       pin_en;
    verdict_t pin_want;

    // Predictor state: link bandwidths and the link count register.
    logic [AMT_W-1:0] link_bw [LINKS];
    logic [CNT_W-1:0] pred_link_count;

    // Generator view: effective link count and links already loaded.
    int  gen_links;
    bit  gen_loaded [LINKS];
    bit  send_burst;

    verdict_t pending_verdicts [$];
    dir_row_t dir_rows [$];

    int errors;
    int idle_cycles;
    int n_loads;
    int n_grants;
    int n_refusals;
    int n_bad_index;
    int n_results;

    link_chain_bandwidth_admission uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predict one request: apply a load or a transfer and return its verdict.
    function automatic verdict_t admit_item(logic op, logic [IDX_W-1:0] idx,
                                            logic [AMT_W-1:0] amount,
                                            logic [NODE_W-1:0] node_a,
                                            logic [NODE_W-1:0] node_b);
        int               n;
        int               lo;
        int               hi;
        logic [NECK_W-1:0] neck;
        verdict_t         v;
        n = (pred_link_count > LINKS) ? LINKS : int'(pred_link_count);
        v.status = ST_OK;
        v.neck = '0;
        if (op == OP_LOAD)
        begin
            if (int'(idx) < n)
                link_bw[idx] = amount;
            else
                v.status = ST_BAD_INDEX;
        end
        else if (node_a == 0 || node_b == 0 || int'(node_a) > n + 1 || int'(node_b) > n + 1)
        begin
            v.status = ST_BAD_INDEX;
        end
        else
        begin
            lo = (node_a < node_b) ? int'(node_a) : int'(node_b);
            hi = (node_a < node_b) ? int'(node_b) : int'(node_a);
            // Links lo-1 .. hi-2 lie between the two nodes.
            neck = '1;
            for (int j = lo - 1; j < hi - 1; j++)
                if (link_bw[j] < neck)
                    neck = link_bw[j];
            v.neck = neck;
            if (neck >= amount)
            begin
                for (int j = lo - 1; j < hi - 1; j++)
                    link_bw[j] = link_bw[j] - amount;
            end
            else
            begin
                v.status = ST_REFUSED;
            end
        end
        return v;
    endfunction

    // Check results, predict accepted requests and watch for a hang.
    always @(posedge clk)
    begin : monitor
        verdict_t want;
        verdict_t predicted;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_wr_en)
                pred_link_count = cfg_wr_data;

            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                n_results++;
                if (pending_verdicts.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, status %0d bottleneck %h",
                             $time, res_ch.status, res_ch.bottleneck);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, res_ch.status);
                    end
                    if (res_ch.bottleneck !== want.neck)
                    begin
                        errors++;
                        $display("%0t: bottleneck mismatch, expected %h actual %h",
                                 $time, want.neck, res_ch.bottleneck);
                    end
                end
            end

            if (cmd_ch.valid && cmd_ch.ready)
            begin
                moved = 1'b1;
                predicted = admit_item(cmd_ch.op, cmd_ch.link_index, cmd_ch.amount,
                                       cmd_ch.first_node, cmd_ch.last_node);
                if (predicted.status == ST_BAD_INDEX)
                    n_bad_index++;
                else if (cmd_ch.op == OP_LOAD)
                    n_loads++;
                else if (predicted.status == ST_OK)
                    n_grants++;
                else
                    n_refusals++;
                pending_verdicts.push_back(pin_en ? pin_want : predicted);
            end

            // Watchdog: too long without any handshake means the block hung.
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_verdicts.size());
                $display("link_chain_bandwidth_admission regression: fail");
                $finish;
            end
        end
    end

    // Result side: after each result, hold ready low for a random stretch, none in burst mode.
    always @(posedge clk)
    begin : result_sink
        int hold;
        int rcv_wait;
        bit rcv_burst;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rcv_wait = 0;
        end
        else if (res_ch.valid && res_ch.ready)
        begin
            if ($urandom_range(0, 39) == 0)
                rcv_burst = !rcv_burst;
            hold = rcv_burst ? 0 : $urandom_range(0, IDLE_MAX);
            rcv_wait = hold;
            res_ch.ready <= (hold == 0);
        end
        else if (rcv_wait != 0)
        begin
            rcv_wait = rcv_wait - 1;
            res_ch.ready <= (rcv_wait == 0);
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // Present one request after a random gap, none in burst mode, and wait until it is taken.
    task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [AMT_W-1:0] amount,
                             logic [NODE_W-1:0] node_a, logic [NODE_W-1:0] node_b,
                             bit pinned, verdict_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.link_index <= idx;
        cmd_ch.amount     <= amount;
        cmd_ch.first_node <= node_a;
        cmd_ch.last_node  <= node_b;
        pin_en            <= pinned;
        pin_want          <= want;
        if (op == OP_LOAD && int'(idx) < gen_links)
            gen_loaded[idx] = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the link count while the block is idle.
    task automatic write_link_count(logic [CNT_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        gen_links = (value > LINKS) ? LINKS : int'(value);
    endtask

    task automatic add_row(row_kind_t kind, logic op, int idx, int amount,
                           int node_a, int node_b, bit pinned, verdict_t want);
        dir_row_t row;
        row.kind   = kind;
        row.op     = op;
        row.idx    = idx[IDX_W-1:0];
        row.amount = amount[AMT_W-1:0];
        row.node_a = node_a[NODE_W-1:0];
        row.node_b = node_b[NODE_W-1:0];
        row.pinned = pinned;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    initial
    begin : stimulus
        dir_row_t         row;
        int               lo;
        int               hi;
        int               unloaded;
        int               n;
        int               r;
        int               a;
        int               b;
        int               off;
        int               cnt;
        int               items;
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [AMT_W-1:0] amt;

        // Known values on every input from time zero.
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_LOAD;
        cmd_ch.link_index = '0;
        cmd_ch.amount     = '0;
        cmd_ch.first_node = '0;
        cmd_ch.last_node  = '0;
        res_ch.ready      = 1'b0;
        pin_en            = 1'b0;
        pin_want          = '0;
        pred_link_count   = CNT_W'(LINK_COUNT_RST);
        gen_links         = (LINK_COUNT_RST > LINKS) ? LINKS : LINK_COUNT_RST;
        foreach (gen_loaded[i])
            gen_loaded[i] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: equal nodes, bad nodes, extremes and each link count corner.
        add_row(ROW_ITEM, OP_XFER, 0, 0, 1, 1, 1, {ST_OK, 16'hFFFF});
        add_row(ROW_ITEM, OP_XFER, 63, 16'hFFFF, 65, 65, 1, {ST_OK, 16'hFFFF});
        add_row(ROW_ITEM, OP_XFER, 0, 3, 0, 5, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_ITEM, OP_XFER, 0, 1, 66, 1, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_ITEM, OP_XFER, 0, 1, 127, 0, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_ITEM, OP_LOAD, 0, 16'hFFFF, 0, 127, 1, {ST_OK, 16'h0000});
        add_row(ROW_ITEM, OP_LOAD, 63, 0, 127, 0, 1, {ST_OK, 16'h0000});
        add_row(ROW_ITEM, OP_LOAD, 1, 16'h1234, 1, 1, 1, {ST_OK, 16'h0000});
        add_row(ROW_ITEM, OP_LOAD, 2, 16'h8000, 1, 1, 1, {ST_OK, 16'h0000});
        add_row(ROW_ITEM, OP_XFER, 0, 16'hFFFF, 1, 2, 1, {ST_OK, 16'hFFFF});
        add_row(ROW_ITEM, OP_XFER, 0, 16'h1235, 3, 1, 0, '0);
        add_row(ROW_ITEM, OP_XFER, 0, 16'h1234, 2, 4, 0, '0);
        add_row(ROW_ITEM, OP_XFER, 0, 0, 64, 65, 0, '0);
        add_row(ROW_ITEM, OP_XFER, 0, 1, 65, 64, 0, '0);
        add_row(ROW_CFG, OP_LOAD, 0, 0, 0, 0, 0, '0);
        add_row(ROW_ITEM, OP_LOAD, 0, 5, 1, 1, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_ITEM, OP_XFER, 0, 9, 1, 1, 1, {ST_OK, 16'hFFFF});
        add_row(ROW_ITEM, OP_XFER, 0, 9, 1, 2, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_CFG, OP_LOAD, 0, 1, 0, 0, 0, '0);
        add_row(ROW_ITEM, OP_LOAD, 0, 5, 1, 2, 1, {ST_OK, 16'h0000});
        add_row(ROW_ITEM, OP_LOAD, 1, 7, 1, 2, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_ITEM, OP_XFER, 0, 5, 2, 1, 0, '0);
        add_row(ROW_ITEM, OP_XFER, 0, 5, 1, 3, 1, {ST_BAD_INDEX, 16'h0000});
        add_row(ROW_CFG, OP_LOAD, 0, 127, 0, 0, 0, '0);
        add_row(ROW_ITEM, OP_LOAD, 63, 16'hAAAA, 0, 0, 1, {ST_OK, 16'h0000});
        add_row(ROW_ITEM, OP_XFER, 0, 16'h5555, 64, 65, 0, '0);
        add_row(ROW_ITEM, OP_XFER, 0, 1, 66, 65, 1, {ST_BAD_INDEX, 16'h0000});

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_link_count(row.amount[CNT_W-1:0]);
            else
                send_item(row.op, row.idx, row.amount, row.node_a, row.node_b,
                          row.pinned, row.want);
        end

        // Random phases, each under its own link count.
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: begin cnt = 64;  items = 350; end
                1: begin cnt = 1;   items = 60;  end
                2: begin cnt = 0;   items = 30;  end
                3: begin cnt = 127; items = 250; end
                4: begin cnt = 37;  items = 200; end
                5: begin cnt = $urandom_range(2, 63); items = 150; end
                default: begin cnt = 64; items = 160; end
            endcase
            write_link_count(cnt[CNT_W-1:0]);
            n = gen_links;
            for (int i = 0; i < items; i++)
            begin
                // Halfway through, let the pipeline run completely dry.
                if (i == items / 2)
                    drain();
                if ($urandom_range(0, 49) == 0)
                    send_burst = !send_burst;

                r   = $urandom_range(0, 99);
                idx = IDX_W'($urandom);
                amt = AMT_W'($urandom);
                a   = $urandom_range(0, 127);
                b   = $urandom_range(0, 127);
                if (r < 30)
                begin
                    // Loads, mostly to links in use.
                    op = OP_LOAD;
                    if (n > 0 && r < 27)
                        idx = IDX_W'($urandom_range(0, n - 1));
                    if ($urandom_range(0, 3) == 0)
                        amt = '1;
                end
                else if (r < 90)
                begin
                    // Well-formed requests, mostly over short ranges.
                    op = OP_XFER;
                    a = $urandom_range(1, n + 1);
                    case ($urandom_range(0, 19))
                        0: begin a = 1; b = n + 1; end
                        1: begin a = n + 1; b = 1; end
                        2, 3: b = $urandom_range(1, n + 1);
                        default:
                        begin
                            off = $urandom_range(0, 8);
                            b = $urandom_range(0, 1) ? a + off : a - off;
                            if (b < 1)
                                b = 1;
                            if (b > n + 1)
                                b = n + 1;
                        end
                    endcase
                    case ($urandom_range(0, 9))
                        0: amt = '0;
                        1: amt = '1;
                        2, 3: amt = AMT_W'($urandom);
                        4, 5, 6: amt = AMT_W'($urandom_range(0, 3000));
                        default: amt = AMT_W'($urandom_range(0, 300));
                    endcase
                end
                else
                begin
                    // Noise: nodes anywhere in their field.
                    op = OP_XFER;
                end

                // A request may never scan a link that was never loaded; load it first.
                if (op == OP_XFER && a >= 1 && b >= 1 && a <= n + 1 && b <= n + 1)
                begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    unloaded = -1;
                    for (int j = lo - 1; j < hi - 1; j++)
                        if (!gen_loaded[j] && unloaded < 0)
                            unloaded = j;
                    if (unloaded >= 0)
                    begin
                        op  = OP_LOAD;
                        idx = IDX_W'(unloaded);
                        amt = AMT_W'($urandom);
                    end
                end
                send_item(op, idx, amt, a[NODE_W-1:0], b[NODE_W-1:0], 0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d results: %0d loads, %0d grants, %0d refusals, %0d bad index",
                 n_results, n_loads, n_grants, n_refusals, n_bad_index);
        $display("Link counts 64, 1, 0, 127, 37 and one random count; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("link_chain_bandwidth_admission regression: pass");
        else
            $display("link_chain_bandwidth_admission regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
